[hdl/fcrgm_pkg.sv]
// ----------------------------------------------------------------------------
// fcrgm_pkg
// Shared types, constants and arithmetic helpers of the ramped gain mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrgm_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int SAMPLE_FIELDS    = 4;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int Q_W      = 23;
    localparam int PROD_W   = Q_W + SAMPLE_W;
    localparam int RECIP_W  = 30;
    localparam int RECIP_SHIFT = 23;

    localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 16'sd1000;
    // ceil(2^36 / 125): |gain| * 65536 / 1000 == (|gain| * RECIP) >> 23
    localparam logic [RECIP_W-1:0] RECIP = 30'd549755814;

    localparam logic [2:0] FUNC_FRAME      = 3'd0;
    localparam logic [2:0] FUNC_SET_GAIN   = 3'd1;
    localparam logic [2:0] FUNC_SET_MASTER = 3'd2;
    localparam logic [2:0] FUNC_MUTE       = 3'd3;
    localparam logic [2:0] FUNC_UNMUTE     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LANE_Q,
        ST_LANE_P,
        ST_MERGE,
        ST_MASTER_Q,
        ST_MASTER_P,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     frame_accept;
        logic                     cmd_accept;
        logic [2:0]               func;
        logic [1:0]               channel;
        logic signed [GAIN_W-1:0] target;
        logic                     q_load;
        logic                     p_load;
    } lane_ctrl_t;

    typedef struct packed {
        logic                     cmd_set;
        logic signed [GAIN_W-1:0] target;
        logic                     tick;
        logic                     q_load;
        logic                     p_load;
    } master_ctrl_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] steps;
        logic              down;
    } ramp_t;

    function automatic ramp_t ramp_plan(input logic signed [GAIN_W-1:0] current,
                                        input logic signed [GAIN_W-1:0] target);
        logic signed [GAIN_W:0] diff;
        logic [GAIN_W:0]        mag;
        ramp_t                  r;
        diff = $signed({target[GAIN_W-1], target}) - $signed({current[GAIN_W-1], current});
        mag = diff[GAIN_W] ? (GAIN_W+1)'(-diff) : (GAIN_W+1)'(diff);
        r.start = mag > (GAIN_W+1)'(2);
        r.steps = {mag[GAIN_W-1:1], 1'b0};
        r.down  = diff[GAIN_W];
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] gain_to_q(input logic signed [GAIN_W-1:0] gain);
        logic [GAIN_W-1:0]         mag;
        logic [GAIN_W+RECIP_W-1:0] prod;
        logic [Q_W-1:0]            qmag;
        mag  = gain[GAIN_W-1] ? GAIN_W'(-gain) : GAIN_W'(gain);
        prod = (GAIN_W+RECIP_W)'(mag) * (GAIN_W+RECIP_W)'(RECIP);
        qmag = prod[RECIP_SHIFT +: Q_W];
        return gain[GAIN_W-1] ? -$signed(qmag) : $signed(qmag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-SAMPLE_W-1:0] sh;
        sh = p[PROD_W-1:SAMPLE_W];
        if (sh > (PROD_W-SAMPLE_W)'(32767))
            return 16'sh7fff;
        else if (sh < -(PROD_W-SAMPLE_W)'(32768))
            return 16'sh8000;
        else
            return sh[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sum(
        input logic signed [SAMPLE_W:0] s);
        if (s[SAMPLE_W] != s[SAMPLE_W-1])
            return s[SAMPLE_W] ? 16'sh8000 : 16'sh7fff;
        else
            return s[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/fcrgm_lane.sv]
// ----------------------------------------------------------------------------
// fcrgm_lane
// One channel: gain ramp, mute state and two-stage sample scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrgm_lane
    import fcrgm_pkg::*;
#(
    parameter int LANE_ID = 0
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic                       present,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic signed [SAMPLE_W-1:0]      scaled
);

    localparam logic [1:0] LANE_SEL = 2'(LANE_ID);

    logic signed [GAIN_W-1:0]   gain_reg, gain_next;
    logic [GAIN_W-1:0]          steps_reg, steps_next;
    logic                       down_reg, down_next;
    logic                       muted_reg, muted_next;
    logic signed [GAIN_W-1:0]   saved_reg, saved_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [Q_W-1:0]      q_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod;
    ramp_t                      plan;
    logic signed [GAIN_W-1:0]   ramp_target;

    always_comb
    begin
        case (ctrl.func)
            FUNC_SET_GAIN: ramp_target = ctrl.target;
            FUNC_UNMUTE:   ramp_target = saved_reg;
            default:       ramp_target = '0;
        endcase
    end

    assign plan = ramp_plan(gain_reg, ramp_target);

    always_comb
    begin
        gain_next  = gain_reg;
        steps_next = steps_reg;
        down_next  = down_reg;
        muted_next = muted_reg;
        saved_next = saved_reg;
        if (ctrl.frame_accept && present && (steps_reg != '0))
        begin
            gain_next  = down_reg ? gain_reg - 16'sd1 : gain_reg + 16'sd1;
            steps_next = steps_reg - 16'd1;
        end
        if (ctrl.cmd_accept && (ctrl.channel == LANE_SEL))
        begin
            case (ctrl.func)
                FUNC_SET_GAIN:
                begin
                    if (muted_reg)
                        saved_next = ctrl.target;
                    else if (plan.start)
                    begin
                        steps_next = plan.steps;
                        down_next  = plan.down;
                    end
                end
                FUNC_MUTE:
                begin
                    muted_next = 1'b1;
                    if (muted_reg)
                        saved_next = '0;
                    else
                    begin
                        saved_next = gain_reg;
                        if (plan.start)
                        begin
                            steps_next = plan.steps;
                            down_next  = plan.down;
                        end
                    end
                end
                FUNC_UNMUTE:
                begin
                    muted_next = 1'b0;
                    if (plan.start)
                    begin
                        steps_next = plan.steps;
                        down_next  = plan.down;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= UNITY_GAIN;
            steps_reg <= '0;
            down_reg  <= 1'b0;
            muted_reg <= 1'b0;
            saved_reg <= UNITY_GAIN;
        end
        else
        begin
            gain_reg  <= gain_next;
            steps_reg <= steps_next;
            down_reg  <= down_next;
            muted_reg <= muted_next;
            saved_reg <= saved_next;
        end
    end

    assign prod = q_reg * sample_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.frame_accept)
            sample_reg <= sample;
        if (ctrl.q_load)
            q_reg <= gain_to_q(gain_reg);
        if (ctrl.p_load)
            prod_reg <= prod;
    end

    assign scaled = sat_prod(prod_reg);

endmodule

`default_nettype wire

[hdl/fcrgm_master.sv]
// ----------------------------------------------------------------------------
// fcrgm_master
// Master gain ramp and two-stage scaling of the merged channel sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrgm_master
    import fcrgm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire master_ctrl_t               ctrl,
    input  wire logic signed [SAMPLE_W-1:0] acc,
    output logic signed [SAMPLE_W-1:0]      result
);

    logic signed [GAIN_W-1:0] gain_reg, gain_next;
    logic [GAIN_W-1:0]        steps_reg, steps_next;
    logic                     down_reg, down_next;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod;
    ramp_t                    plan;

    assign plan = ramp_plan(gain_reg, ctrl.target);

    always_comb
    begin
        gain_next  = gain_reg;
        steps_next = steps_reg;
        down_next  = down_reg;
        if (ctrl.tick && (steps_reg != '0))
        begin
            gain_next  = down_reg ? gain_reg - 16'sd1 : gain_reg + 16'sd1;
            steps_next = steps_reg - 16'd1;
        end
        if (ctrl.cmd_set && plan.start)
        begin
            steps_next = plan.steps;
            down_next  = plan.down;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= UNITY_GAIN;
            steps_reg <= '0;
            down_reg  <= 1'b0;
        end
        else
        begin
            gain_reg  <= gain_next;
            steps_reg <= steps_next;
            down_reg  <= down_next;
        end
    end

    assign prod = q_reg * acc;

    always_ff @(posedge clk)
    begin
        if (ctrl.q_load)
            q_reg <= gain_to_q(gain_reg);
        if (ctrl.p_load)
            prod_reg <= prod;
    end

    assign result = sat_prod(prod_reg);

endmodule

`default_nettype wire

[hdl/four_channel_ramped_gain_mixer.sv]
// ----------------------------------------------------------------------------
// four_channel_ramped_gain_mixer
// Four-input mixer with per-channel ramped gains, mute and master gain.
//
//   channel  handshake               payload
//   frame    frame_valid/frame_stall func, channel_index, gain_target,
//                                    present_mask, sample_ch0..sample_ch3
//   mix      mix_valid/mix_stall     mix_sample
//
// A frame with a present sample passes through accept, lane Q16 multiply,
// lane sample multiply, saturating merge, master Q16 multiply, master
// multiply, output load. Commands and empty frames cause no busy state.
// One result register; the next request is taken while a result waits.
// Reset sets all gains to unity, clears ramps and mute flags.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_ramped_gain_mixer
    import fcrgm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        frame_valid,
    output logic                             frame_stall,
    input  wire logic [2:0]                  func,
    input  wire logic [1:0]                  channel_index,
    input  wire logic signed [GAIN_W-1:0]    gain_target,
    input  wire logic [SAMPLE_FIELDS-1:0]    present_mask,
    input  wire logic signed [SAMPLE_W-1:0]  sample_ch0,
    input  wire logic signed [SAMPLE_W-1:0]  sample_ch1,
    input  wire logic signed [SAMPLE_W-1:0]  sample_ch2,
    input  wire logic signed [SAMPLE_W-1:0]  sample_ch3,
    output logic                             mix_valid,
    input  wire logic                        mix_stall,
    output logic signed [SAMPLE_W-1:0]       mix_sample
);

    localparam int LANES = (NUM_CHANNELS < SAMPLE_FIELDS) ? NUM_CHANNELS : SAMPLE_FIELDS;

    state_t                     state_reg, state_next;
    logic                       accept;
    logic                       frame_go;
    logic [LANES-1:0]           present_reg;
    logic signed [SAMPLE_W-1:0] sample_in [SAMPLE_FIELDS];
    logic signed [SAMPLE_W-1:0] lane_scaled [LANES];
    logic signed [SAMPLE_W-1:0] acc_reg;
    logic signed [SAMPLE_W-1:0] merge_sum;
    logic signed [SAMPLE_W-1:0] master_result;
    logic                       mix_valid_reg;
    logic signed [SAMPLE_W-1:0] mix_reg;
    lane_ctrl_t                 lane_ctrl;
    master_ctrl_t               master_ctrl;
    logic                       merge_load;
    logic                       out_load;

    assign sample_in[0] = sample_ch0;
    assign sample_in[1] = sample_ch1;
    assign sample_in[2] = sample_ch2;
    assign sample_in[3] = sample_ch3;

    assign accept   = frame_valid && !frame_stall;
    assign frame_go = accept && (func == FUNC_FRAME) && (|present_mask[LANES-1:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (frame_go) state_next = ST_LANE_Q;
            ST_LANE_Q:   state_next = ST_LANE_P;
            ST_LANE_P:   state_next = ST_MERGE;
            ST_MERGE:    state_next = ST_MASTER_Q;
            ST_MASTER_Q: state_next = ST_MASTER_P;
            ST_MASTER_P: state_next = ST_OUT;
            ST_OUT:      if (!mix_valid_reg || !mix_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        frame_stall = (state_reg != ST_IDLE);
        merge_load  = (state_reg == ST_MERGE);
        out_load    = (state_reg == ST_OUT) && (!mix_valid_reg || !mix_stall);

        lane_ctrl.frame_accept = frame_go;
        lane_ctrl.cmd_accept   = accept;
        lane_ctrl.func         = func;
        lane_ctrl.channel      = channel_index;
        lane_ctrl.target       = gain_target;
        lane_ctrl.q_load       = (state_reg == ST_LANE_Q);
        lane_ctrl.p_load       = (state_reg == ST_LANE_P);

        master_ctrl.cmd_set = accept && (func == FUNC_SET_MASTER);
        master_ctrl.target  = gain_target;
        master_ctrl.tick    = (state_reg == ST_MERGE);
        master_ctrl.q_load  = (state_reg == ST_MASTER_Q);
        master_ctrl.p_load  = (state_reg == ST_MASTER_P);
    end

    genvar gi;
    generate
        for (gi = 0; gi < LANES; gi++)
        begin : g_lane
            fcrgm_lane #(
                .LANE_ID (gi)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (lane_ctrl),
                .present (present_mask[gi]),
                .sample  (sample_in[gi]),
                .scaled  (lane_scaled[gi])
            );
        end
    endgenerate

    // saturate at every addition, in channel order
    always_comb
    begin
        logic any;
        any       = 1'b0;
        merge_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (present_reg[i])
            begin
                merge_sum = any ? sat_sum($signed({merge_sum[SAMPLE_W-1], merge_sum})
                                        + $signed({lane_scaled[i][SAMPLE_W-1],
                                                   lane_scaled[i]}))
                                : lane_scaled[i];
                any = 1'b1;
            end
        end
    end

    fcrgm_master u_master (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (master_ctrl),
        .acc    (acc_reg),
        .result (master_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                mix_valid_reg <= 1'b1;
            else if (!mix_stall)
                mix_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_go)
            present_reg <= present_mask[LANES-1:0];
        if (merge_load)
            acc_reg <= merge_sum;
        if (out_load)
            mix_reg <= master_result;
    end

    assign mix_valid  = mix_valid_reg;
    assign mix_sample = mix_reg;

endmodule

`default_nettype wire

[hdl/fcrgm_checker.sv]
// ----------------------------------------------------------------------------
// fcrgm_checker
// Port-level checks of the ramped gain mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrgm_checker
    import fcrgm_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       frame_valid,
    input wire logic                       frame_stall,
    input wire logic [2:0]                 func,
    input wire logic [SAMPLE_FIELDS-1:0]   present_mask,
    input wire logic                       mix_valid,
    input wire logic                       mix_stall,
    input wire logic signed [SAMPLE_W-1:0] mix_sample
);

    logic accept;

    assign accept = frame_valid && !frame_stall;

    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix_stall |=> mix_valid && $stable(mix_sample))
        else $error("stalled result changed or dropped");

    a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func != FUNC_FRAME) && !mix_valid |=> !mix_valid)
        else $error("command produced a result");

    a_empty_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_FRAME) && (present_mask == '0) && !mix_valid
        |=> !mix_valid)
        else $error("empty frame produced a result");

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_FRAME) && present_mask[0] |=> frame_stall)
        else $error("frame in progress did not hold off requests");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mix_valid) |-> $past(frame_stall))
        else $error("result appeared without a frame in progress");

endmodule

bind four_channel_ramped_gain_mixer fcrgm_checker u_fcrgm_checker (.*);

`default_nettype wire
